@@ rtl/hvt_pkg.sv @@
// Shared types, constants and field layouts for the homogeneous vertex transform.
package hvt_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIST_W    = 31;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int IDX_W     = $clog2(DIM * DIM);
  localparam int K_W       = $clog2(DIM);
  localparam int QCNT_W    = $clog2(COORD_W);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_XFORM = 2'd1;
  localparam logic [1:0] MODE_PROJ  = 2'd2;

  localparam logic [DIST_W-1:0]  DIST_RESET = DIST_W'(65536);
  localparam logic [COORD_W-1:0] ONE_Q      = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] SAT_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN    = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                mode;
    logic [3:0]                entry_index;
    logic signed [COORD_W-1:0] entry_value;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_w;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_w;
    logic                      div_error;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   num;
    logic [COORD_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [COORD_W-1:0]  quot;
  } div_rsp_t;

endpackage

@@ rtl/homogeneous_vertex_transform.sv @@
// Homogeneous 4x4 vertex transform with perspective divide: sequencer, matrix and datapath.
// A load item writes one matrix entry and leaves the sequencer idle. A transform item runs
// the sixteen products through the one shared multiplier, each product through a multiply and
// an accumulate state, with a store state per column, and its result is presented from the
// finish state, and the next item can be taken in the cycle after. A perspective item uses
// the same multiplier for x*d and y*d and then the bit-serial divider for each quotient; a
// quotient that cannot fit skips the divider steps, and with z equal to zero the divider is
// not used. No new item is taken while one is in work; a finished result sits in the output
// register, so the next item may start before it is taken, and an item that finishes while
// that register is still full waits until it is free.
module homogeneous_vertex_transform
  import hvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_STORE, S_PMUL, S_PDIV, S_PWAIT, S_FIN
  } state_t;

  state_t                    state;
  logic signed [COORD_W-1:0] matrix [DIM*DIM];
  logic signed [COORD_W-1:0] pt [DIM];
  logic signed [COORD_W-1:0] res [DIM];
  logic [DIST_W-1:0]         proj_dist;
  logic [K_W-1:0]            j;
  logic [K_W-1:0]            k;
  logic signed [ACC_W-1:0]   acc;
  logic                      neg;
  logic                      err;

  logic signed [COORD_W-1:0] mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic signed [ACC_W-1:0]   acc_sh;
  logic [COORD_W-1:0]        col_sat;
  logic [COORD_W-1:0]        zero_sat;
  logic [COORD_W-1:0]        quot_sat;
  logic                      z_zero;

  hvt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  hvt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign z_zero   = (pt[2] == '0);

  always_comb begin
    mul_a = pt[k];
    mul_b = (state == S_PMUL) ? $signed({1'b0, proj_dist}) : matrix[{k, j}];

    div_req.start = (state == S_PDIV) && !z_zero;
    div_req.num   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    div_req.den   = pt[2][COORD_W-1] ? COORD_W'(-pt[2]) : COORD_W'(pt[2]);

    acc_sh = acc >>> FRAC_BITS;
    if (!acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:COORD_W-1])) begin
      col_sat = SAT_MAX;
    end else if (acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:COORD_W-1])) begin
      col_sat = SAT_MIN;
    end else begin
      col_sat = acc_sh[COORD_W-1:0];
    end

    if (prod == '0) begin
      zero_sat = '0;
    end else if (prod[PROD_W-1]) begin
      zero_sat = SAT_MIN;
    end else begin
      zero_sat = SAT_MAX;
    end

    if (div_rsp.ovf) begin
      quot_sat = neg ? SAT_MIN : SAT_MAX;
    end else if (!neg) begin
      quot_sat = div_rsp.quot[COORD_W-1] ? SAT_MAX : div_rsp.quot;
    end else begin
      quot_sat = (div_rsp.quot > SAT_MIN) ? SAT_MIN : COORD_W'(-div_rsp.quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      proj_dist <= DIST_RESET;
      j         <= '0;
      k         <= '0;
      for (int i = 0; i < DIM*DIM; i++) begin
        matrix[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        proj_dist <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pt[0] <= in_data.point_x;
            pt[1] <= in_data.point_y;
            pt[2] <= in_data.point_z;
            pt[3] <= in_data.point_w;
            j     <= '0;
            k     <= '0;
            acc   <= '0;
            case (in_data.mode)
              MODE_LOAD:  matrix[in_data.entry_index] <= in_data.entry_value;
              MODE_XFORM: state <= S_MUL;
              MODE_PROJ:  state <= S_PMUL;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc <= acc + ACC_W'(prod);
          if (k == K_W'(DIM - 1)) begin
            state <= S_STORE;
          end else begin
            k     <= k + K_W'(1);
            state <= S_MUL;
          end
        end
        S_STORE: begin
          res[j] <= col_sat;
          acc    <= '0;
          k      <= '0;
          err    <= 1'b0;
          if (j == K_W'(DIM - 1)) begin
            state <= S_FIN;
          end else begin
            j     <= j + K_W'(1);
            state <= S_MUL;
          end
        end
        S_PMUL: state <= S_PDIV;
        S_PDIV: begin
          neg <= prod[PROD_W-1] ^ pt[2][COORD_W-1];
          if (z_zero) begin
            res[k] <= zero_sat;
            if (k == K_W'(1)) begin
              res[2] <= COORD_W'(proj_dist);
              res[3] <= ONE_Q;
              err    <= 1'b1;
              state  <= S_FIN;
            end else begin
              k     <= K_W'(1);
              state <= S_PMUL;
            end
          end else begin
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (div_rsp.done) begin
            res[k] <= quot_sat;
            if (k == K_W'(1)) begin
              res[2] <= COORD_W'(proj_dist);
              res[3] <= ONE_Q;
              err    <= 1'b0;
              state  <= S_FIN;
            end else begin
              k     <= K_W'(1);
              state <= S_PMUL;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.out_x     <= res[0];
            out_data.out_y     <= res[1];
            out_data.out_z     <= res[2];
            out_data.out_w     <= res[3];
            out_data.div_error <= err;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.den != '0))
    else $error("divider started with zero divisor");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_PWAIT))
    else $error("divider finished outside wait state");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result presented without finishing an item");

  a_err_is_proj: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.div_error) |-> (out_data.out_w == ONE_Q))
    else $error("error flag on a non-perspective result");

endmodule

@@ rtl/hvt_mul.sv @@
// Shared signed 32x32 multiplier with registered product.
module hvt_mul
  import hvt_pkg::*;
(
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/hvt_div.sv @@
// Bit-serial restoring divider: 64-bit magnitude by 32-bit magnitude, 32 quotient bits.
module hvt_div
  import hvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic                ovf;
  logic [QCNT_W-1:0]   cnt;
  logic [COORD_W-1:0]  rem;
  logic [COORD_W-1:0]  ql;
  logic [COORD_W-1:0]  den;
  logic [COORD_W:0]    trial;
  logic [COORD_W:0]    diff;
  logic                qbit;
  logic [COORD_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, ql[COORD_W-1]};
    diff     = trial - {1'b0, den};
    qbit     = trial >= {1'b0, den};
    rem_next = qbit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den <= req.den;
        if (req.num[PROD_W-1:COORD_W] >= req.den) begin
          ovf  <= 1'b1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          ovf  <= 1'b0;
          rem  <= req.num[PROD_W-1:COORD_W];
          ql   <= req.num[COORD_W-1:0];
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        ql  <= {ql[COORD_W-2:0], qbit};
        cnt <= cnt + QCNT_W'(1);
        if (cnt == {QCNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = ql;

endmodule
